@@ hw/rtl/tsgs_pkg.sv @@
`default_nettype none

package tsgs_pkg;

	// Width of one code point and of the cluster index field.
	localparam int unsigned CODE_BITS          = 21;
	localparam int unsigned CIDX_BITS          = 16;
	localparam int unsigned BURST_MAX          = 3;
	localparam int unsigned CLUSTER_INDEX_BITS = 16;

	// Tamil code points of interest.
	localparam logic [CODE_BITS-1:0] LIG_BASE   = 21'h00EB80;
	localparam logic [CODE_BITS-1:0] CONS_FIRST = 21'h000B95;
	localparam logic [CODE_BITS-1:0] CONS_LAST  = 21'h000BB9;
	localparam logic [CODE_BITS-1:0] SIGN_AA    = 21'h000BBE;
	localparam logic [CODE_BITS-1:0] SIGN_I     = 21'h000BBF;
	localparam logic [CODE_BITS-1:0] SIGN_II    = 21'h000BC0;
	localparam logic [CODE_BITS-1:0] SIGN_U     = 21'h000BC1;
	localparam logic [CODE_BITS-1:0] SIGN_UU    = 21'h000BC2;
	localparam logic [CODE_BITS-1:0] SIGN_E     = 21'h000BC6;
	localparam logic [CODE_BITS-1:0] SIGN_EE    = 21'h000BC7;
	localparam logic [CODE_BITS-1:0] SIGN_AI    = 21'h000BC8;
	localparam logic [CODE_BITS-1:0] SIGN_O     = 21'h000BCA;
	localparam logic [CODE_BITS-1:0] SIGN_OO    = 21'h000BCB;
	localparam logic [CODE_BITS-1:0] SIGN_AU    = 21'h000BCC;
	localparam logic [CODE_BITS-1:0] VIRAMA     = 21'h000BCD;
	localparam logic [CODE_BITS-1:0] AU_MARK    = 21'h000BD7;

	// Ligature block offsets for the fused signs.
	localparam logic [CODE_BITS-1:0] BLOCK_I      = 21'h000000;
	localparam logic [CODE_BITS-1:0] BLOCK_II     = 21'h000018;
	localparam logic [CODE_BITS-1:0] BLOCK_U      = 21'h000030;
	localparam logic [CODE_BITS-1:0] BLOCK_UU     = 21'h000048;
	localparam logic [CODE_BITS-1:0] BLOCK_VIRAMA = 21'h000060;

	// One bit per code point of the consonant range, set for real consonants.
	localparam logic [39:0] CONSONANT_MASK = 40'h1DFE38C6B1;

	typedef struct packed {
		logic [CODE_BITS-1:0] code_point;
		logic                 end_of_text;
	} chars_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] glyph_code;
		logic [CIDX_BITS-1:0] cluster_index;
		logic                 run_end;
	} glyphs_t;

	// Up to three glyphs produced by one character.
	typedef struct packed {
		logic [1:0]                          cnt;
		logic [BURST_MAX-1:0][CODE_BITS-1:0] glyph;
		logic [BURST_MAX-1:0][CIDX_BITS-1:0] cidx;
	} burst_t;

	function automatic logic tsgs_is_cons(input logic [CODE_BITS-1:0] c);
		logic [CODE_BITS-1:0] d;
		d = c - CONS_FIRST;
		if (c < CONS_FIRST || c > CONS_LAST) begin
			return 1'b0;
		end
		return CONSONANT_MASK[d[5:0]];
	endfunction

	function automatic logic tsgs_is_sign(input logic [CODE_BITS-1:0] c);
		return (c >= SIGN_AA && c <= SIGN_UU) || (c >= SIGN_E && c <= SIGN_AI) ||
			(c >= SIGN_O && c <= VIRAMA) || (c == AU_MARK);
	endfunction

	// Position of a consonant within a ligature block.
	function automatic logic [4:0] tsgs_cons_slot(input logic [5:0] d);
		logic [4:0] s;
		unique case (d)
			6'd4:    s = 5'd1;
			6'd5:    s = 5'd2;
			6'd7:    s = 5'd3;
			6'd9:    s = 5'd4;
			6'd10:   s = 5'd5;
			6'd14:   s = 5'd6;
			6'd15:   s = 5'd7;
			6'd19:   s = 5'd8;
			6'd20:   s = 5'd9;
			6'd21:   s = 5'd10;
			6'd25:   s = 5'd11;
			6'd26:   s = 5'd12;
			6'd27:   s = 5'd13;
			6'd28:   s = 5'd14;
			6'd29:   s = 5'd15;
			6'd30:   s = 5'd16;
			6'd31:   s = 5'd17;
			6'd32:   s = 5'd18;
			6'd34:   s = 5'd20;
			6'd35:   s = 5'd21;
			6'd36:   s = 5'd22;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsgs_shaper.sv @@
`default_nettype none

module tsgs_shaper #(
	parameter int unsigned CLUSTER_INDEX_BITS = tsgs_pkg::CLUSTER_INDEX_BITS
) (
	input  var tsgs_pkg::chars_t                              item,
	input  var logic                                          pend_v,
	input  var logic [tsgs_pkg::CODE_BITS-1:0]                pend_c,
	input  var logic [CLUSTER_INDEX_BITS-1:0]                 cs,
	output tsgs_pkg::burst_t                                  burst,
	output logic                                              pend_v_next,
	output logic [tsgs_pkg::CODE_BITS-1:0]                    pend_c_next,
	output logic [CLUSTER_INDEX_BITS-1:0]                     cs_next
);
	import tsgs_pkg::*;

	localparam logic [CLUSTER_INDEX_BITS-1:0] CS_ONE = CLUSTER_INDEX_BITS'(1);
	localparam logic [CLUSTER_INDEX_BITS-1:0] CS_TWO = CLUSTER_INDEX_BITS'(2);

	logic [CODE_BITS-1:0]          c;
	logic                          sign;
	logic                          cons;
	logic                          emit_char;
	logic [CODE_BITS-1:0]          slot;
	logic [CODE_BITS-1:0]          lig;
	logic [CLUSTER_INDEX_BITS-1:0] cs1;
	logic [CLUSTER_INDEX_BITS-1:0] cs2;
	logic [CIDX_BITS-1:0]          ci0;
	logic [CIDX_BITS-1:0]          ci1;

	assign c    = item.code_point;
	assign sign = tsgs_is_sign(c);
	assign cons = tsgs_is_cons(c);
	assign cs1  = cs + CS_ONE;
	assign cs2  = cs + CS_TWO;
	assign ci0  = CIDX_BITS'(cs);
	assign ci1  = CIDX_BITS'(cs1);
	assign slot = CODE_BITS'(tsgs_cons_slot(6'(pend_c - CONS_FIRST)));

	// The character itself is emitted unless it is a consonant that stays held.
	assign emit_char = !cons || item.end_of_text;

	// Ligature code for the fused vowel signs and the virama.
	always_comb begin
		unique case (c)
			SIGN_I:  lig = LIG_BASE + BLOCK_I + slot;
			SIGN_II: lig = LIG_BASE + BLOCK_II + slot;
			SIGN_U:  lig = LIG_BASE + BLOCK_U + slot;
			SIGN_UU: lig = LIG_BASE + BLOCK_UU + slot;
			default: lig = LIG_BASE + BLOCK_VIRAMA + slot;
		endcase
	end

	// Glyph burst and next look-behind state for one character.
	always_comb begin
		burst       = '0;
		pend_v_next = pend_v;
		pend_c_next = pend_c;
		cs_next     = cs;
		if (sign && pend_v) begin
			burst.cidx  = {ci0, ci0, ci0};
			cs_next     = cs2;
			pend_v_next = 1'b0;
			unique case (c) inside
				SIGN_AA: begin
					burst.cnt      = 2'd2;
					burst.glyph[0] = pend_c;
					burst.glyph[1] = SIGN_AA;
				end
				SIGN_I, SIGN_II, SIGN_U, SIGN_UU, VIRAMA: begin
					burst.cnt      = 2'd1;
					burst.glyph[0] = lig;
				end
				SIGN_E, SIGN_EE, SIGN_AI: begin
					burst.cnt      = 2'd2;
					burst.glyph[0] = c;
					burst.glyph[1] = pend_c;
				end
				SIGN_O, SIGN_OO, SIGN_AU: begin
					burst.cnt      = 2'd3;
					burst.glyph[0] = (c == SIGN_OO) ? SIGN_EE : SIGN_E;
					burst.glyph[1] = pend_c;
					burst.glyph[2] = (c == SIGN_AU) ? AU_MARK : SIGN_AA;
				end
				default: begin
					// The AU length mark drops; only the consonant is shown.
					burst.cnt      = 2'd1;
					burst.glyph[0] = pend_c;
				end
			endcase
		end else if (sign) begin
			burst.cnt      = 2'd1;
			burst.glyph[0] = c;
			burst.cidx[0]  = ci0;
			cs_next        = cs1;
		end else begin
			// Flush the held consonant, then emit or hold the new character.
			if (pend_v) begin
				burst.glyph[0] = pend_c;
				burst.cidx[0]  = ci0;
				if (emit_char) begin
					burst.cnt      = 2'd2;
					burst.glyph[1] = c;
					burst.cidx[1]  = ci1;
				end else begin
					burst.cnt = 2'd1;
				end
			end else if (emit_char) begin
				burst.cnt      = 2'd1;
				burst.glyph[0] = c;
				burst.cidx[0]  = ci0;
			end
			cs_next = cs + (pend_v ? CS_ONE : '0) + (cons ? '0 : CS_ONE);
			pend_v_next = cons;
			if (cons) begin
				pend_c_next = c;
			end
		end
		// End of text starts a fresh run.
		if (item.end_of_text) begin
			pend_v_next = 1'b0;
			pend_c_next = '0;
			cs_next     = '0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tamil_syllable_glyph_shaper_core.sv @@
// Tamil syllable shaper: takes one Unicode code point per request on the chars channel
// and returns glyph codes on the glyphs channel, one glyph per request, each with the
// character index where its cluster starts and run_end set on the last glyph of a
// character. A consonant is held back until the next character shows whether a vowel
// sign reorders it, splits around it or fuses with it into a private-use ligature.
// A character that yields n glyphs occupies the glyph burst register until all n have
// moved out, so the block takes one character per cycle while each yields at most one
// glyph and glyphs_stall is low; otherwise the next character waits until the burst
// drains, since the glyph output takes one glyph at a time. The first glyph of a
// character passes the input, burst and output registers in turn before it is presented.
// Setting end_of_text flushes the held consonant and resets the cluster index to zero.
`default_nettype none

module tamil_syllable_glyph_shaper_core #(
	parameter int unsigned CLUSTER_INDEX_BITS = tsgs_pkg::CLUSTER_INDEX_BITS
) (
	input  var logic             clk,
	input  var logic             arst_n,
	input  var logic             chars_valid,
	output logic                 chars_stall,
	input  var tsgs_pkg::chars_t chars,
	output logic                 glyphs_valid,
	input  var logic             glyphs_stall,
	output tsgs_pkg::glyphs_t    glyphs
);
	import tsgs_pkg::*;

	logic                          valid_s1;
	chars_t                        item_s1;
	logic [1:0]                    cnt_s2;
	logic [1:0]                    pos_s2;
	logic [BURST_MAX-1:0][CODE_BITS-1:0] glyph_s2;
	logic [BURST_MAX-1:0][CIDX_BITS-1:0] cidx_s2;
	logic                          out_valid_q;
	glyphs_t                       out_q;
	logic                          pend_v_q;
	logic [CODE_BITS-1:0]          pend_c_q;
	logic [CLUSTER_INDEX_BITS-1:0] cs_q;

	burst_t                        burst;
	logic                          pend_v_next;
	logic [CODE_BITS-1:0]          pend_c_next;
	logic [CLUSTER_INDEX_BITS-1:0] cs_next;
	logic                          chars_accept;
	logic                          move;
	logic                          s2_free;
	logic                          adv_s1;

	// Handshake control between the three register levels.
	assign move         = (cnt_s2 != 2'd0) && (!out_valid_q || !glyphs_stall);
	assign s2_free      = (cnt_s2 == 2'd0) || ((cnt_s2 == 2'd1) && move);
	assign adv_s1       = valid_s1 && s2_free;
	assign chars_stall  = valid_s1 && !s2_free;
	assign chars_accept = chars_valid && !chars_stall;
	assign glyphs_valid = out_valid_q;
	assign glyphs       = out_q;

	tsgs_shaper #(
		.CLUSTER_INDEX_BITS(CLUSTER_INDEX_BITS)
	) u_shaper (
		.item       (item_s1),
		.pend_v     (pend_v_q),
		.pend_c     (pend_c_q),
		.cs         (cs_q),
		.burst      (burst),
		.pend_v_next(pend_v_next),
		.pend_c_next(pend_c_next),
		.cs_next    (cs_next)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars_accept) begin
			item_s1 <= chars;
		end
	end

	// Look-behind state, updated when a character leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_c_q <= '0;
			cs_q     <= '0;
		end else if (adv_s1) begin
			pend_v_q <= pend_v_next;
			pend_c_q <= pend_c_next;
			cs_q     <= cs_next;
		end
	end

	// Burst register: count of glyphs left and read position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
			pos_s2 <= 2'd0;
		end else if (adv_s1) begin
			cnt_s2 <= burst.cnt;
			pos_s2 <= 2'd0;
		end else if (move) begin
			cnt_s2 <= cnt_s2 - 2'd1;
			pos_s2 <= pos_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			glyph_s2 <= burst.glyph;
			cidx_s2  <= burst.cidx;
		end
	end

	// Output register, loaded one glyph at a time from the burst.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!glyphs_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.glyph_code    <= glyph_s2[pos_s2];
			out_q.cluster_index <= cidx_s2[pos_s2];
			out_q.run_end       <= (cnt_s2 == 2'd1);
		end
	end

`ifndef SYNTHESIS
	// A held consonant is always a real consonant.
	a_pend_is_cons: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> tsgs_is_cons(pend_c_q))
		else $error("held code point is not a consonant");

	// End of text leaves nothing held and the cluster index at zero.
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.end_of_text) |=> (!pend_v_q && (cs_q == '0)))
		else $error("end of text did not clear the look-behind state");

	// run_end marks exactly the last glyph moved out of a burst.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> (out_q.run_end == ($past(cnt_s2) == 2'd1)))
		else $error("run_end does not match the burst position");

	// The burst position never runs past the stored glyphs.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s2 != 2'd0) |-> ((pos_s2 + cnt_s2) <= 3'(BURST_MAX)))
		else $error("burst read position out of range");
`endif

endmodule

`default_nettype wire
